// File: rtl/core/gnf_pkg.sv
`default_nettype none
package gnf_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TBL_W      = $clog2(TABLE_SIZE);
  localparam int MAX_LAYERS = 16;
  localparam int CNT_W      = 6;
  localparam int QDEPTH     = 2;
  localparam int QA_W       = $clog2(QDEPTH);
  localparam int ACC_W      = 40;
  localparam int K_W        = 21;
  localparam int P_W        = 24;

  localparam logic [4:0] LAST_STEP  = 5'd23;
  localparam logic [4:0] SCALE_LAST = 5'd2;

  localparam logic [1:0] CFG_BASE_FREQ   = 2'd0;
  localparam logic [1:0] CFG_FREQ_FACTOR = 2'd1;
  localparam logic [1:0] CFG_AMP_FACTOR  = 2'd2;
  localparam logic [1:0] CFG_LAYER_COUNT = 2'd3;

  localparam logic signed [24:0] FC_6  = 25'sd6;
  localparam logic signed [24:0] FC_10 = 25'sd10;
  localparam logic signed [24:0] FC_15 = 25'sd15;
  localparam logic signed [24:0] FC_30 = 25'sd30;
  localparam logic signed [24:0] FC_60 = 25'sd60;
  localparam logic [16:0] FIX_ONE = 17'h10000;

  typedef enum logic {REQ_LOAD = 1'b0, REQ_EVAL = 1'b1} req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] px;
    logic [31:0] py;
  } req_t;

  typedef struct packed {
    logic [15:0] base_freq;
    logic [15:0] freq_factor;
    logic [15:0] amp_factor;
    logic [4:0]  layer_count;
  } cfg_t;

  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_SCALE, ST_LAYER, ST_DONE} eng_state_t;

  typedef struct packed {
    logic [16:0] f;
    logic [17:0] df;
  } fade_t;

  function automatic logic signed [18:0] grad(input logic [1:0] h,
                                              input logic signed [16:0] x,
                                              input logic signed [16:0] y);
    logic signed [18:0] xe;
    logic signed [18:0] ye;
    logic signed [18:0] r;
    xe = 19'(x);
    ye = 19'(y);
    case (h)
      2'd0: r = xe + ye;
      2'd1: r = ye - xe;
      2'd2: r = xe - ye;
      default: r = -xe - ye;
    endcase
    return r;
  endfunction

  function automatic fade_t fade(input logic [15:0] t2, input logic [15:0] t3,
                                 input logic [15:0] t4, input logic [15:0] t5);
    logic signed [24:0] fv;
    logic signed [24:0] dv;
    fade_t r;
    fv = FC_6 * $signed({9'b0, t5}) - FC_15 * $signed({9'b0, t4})
       + FC_10 * $signed({9'b0, t3});
    dv = FC_30 * $signed({9'b0, t4}) - FC_60 * $signed({9'b0, t3})
       + FC_30 * $signed({9'b0, t2});
    if (fv < 0) r.f = '0;
    else if (fv > $signed({8'b0, FIX_ONE})) r.f = FIX_ONE;
    else r.f = fv[16:0];
    r.df = (dv < 0) ? '0 : dv[17:0];
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(ACC_W'(32'sh7fffffff))) r = 32'h7fffffff;
    else if (v < -$signed(ACC_W'(33'h080000000))) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [7:0] tmask(input logic [7:0] v);
    return v & 8'(TABLE_SIZE - 1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/gnf_front.sv
`default_nettype none
module gnf_front
  import gnf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // table_index, table_value, point_x, point_y
  input  wire logic        s_axis_tuser,  // req_type
  output logic             q_valid,
  output req_t             q_req,
  input  wire logic        q_pop
);

  req_t            slots [QDEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;
  logic            push;
  req_t            in_req;

  assign s_axis_tready = (count != (QA_W+1)'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign q_req         = slots[rd_ptr];

  always_comb begin
    in_req.kind = s_axis_tuser ? REQ_EVAL : REQ_LOAD;
    in_req.idx  = s_axis_tdata[7:0];
    in_req.val  = s_axis_tdata[15:8];
    in_req.px   = s_axis_tdata[47:16];
    in_req.py   = s_axis_tdata[79:48];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gnf_back.sv
`default_nettype none
module gnf_back
  import gnf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire req_t        q_req,
  output logic             q_pop,
  input  wire cfg_t        cfg,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata   // noise_value, deriv_x, deriv_y
);

  eng_state_t state, state_next;
  logic [4:0]       step;
  logic [CNT_W-1:0] lyr;
  logic [CNT_W-1:0] n_layers;
  logic             last_layer;
  logic             out_free;
  logic             mem_we;
  req_t             req;

  logic [7:0] mem [256];
  logic       vld [256];
  logic [7:0] ra, ra_q, rq_raw, rq;
  logic       vld_q;

  logic signed [32:0] opa;
  logic signed [21:0] opb;
  logic signed [54:0] p;
  logic signed [38:0] psh;

  logic [31:0] cx, cy;
  logic [16:0] amp;
  logic [15:0] t2x, t3x, t4x, t5x, t2y, t3y, t4y, t5y;
  logic [15:0] tx, ty;
  logic [7:0]  px0, px1, y0;
  logic [1:0]  ha, hb, hc, hd;
  logic [16:0] u, v;
  logic [17:0] du, dv;
  logic signed [18:0] a, ga, gb, gc, gd;
  logic signed [K_W-1:0] k0, k1, k2;
  logic signed [P_W-1:0] uk0, vk1, uv, uvk2, duk0, duv, duvk2, dvk1, udv, udvk2, lv;
  logic signed [ACC_W-1:0] acc_v, acc_dx, acc_dy;
  fade_t fx, fy;

  assign tx = cx[15:0];
  assign ty = cy[15:0];
  assign y0 = cy[23:16];
  assign n_layers = (6'(cfg.layer_count) > CNT_W'(MAX_LAYERS)) ? CNT_W'(MAX_LAYERS)
                                                             : 6'(cfg.layer_count);
  assign last_layer = ((lyr + 1'b1) == n_layers);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign psh        = p[54:16];
  assign rq         = vld_q ? rq_raw : ra_q;

  assign fx = fade(t2x, t3x, t4x, t5x);
  assign fy = fade(t2y, t3y, t4y, t5y);
  assign ga = grad(ha, $signed({1'b0, tx}), $signed({1'b0, ty}));
  assign gb = grad(hb, $signed({1'b1, tx}), $signed({1'b0, ty}));
  assign gc = grad(hc, $signed({1'b0, tx}), $signed({1'b1, ty}));
  assign gd = grad(hd, $signed({1'b1, tx}), $signed({1'b1, ty}));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = (q_req.kind == REQ_LOAD) ? ST_LOAD : ST_SCALE;
      ST_LOAD:  state_next = ST_DONE;
      ST_SCALE: if (step == SCALE_LAST) state_next = (n_layers == '0) ? ST_DONE : ST_LAYER;
      ST_LAYER: if (step == LAST_STEP && last_layer) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop  = (state == ST_IDLE) && q_valid;
    mem_we = (state == ST_LOAD);
  end

  // table read address per step
  always_comb begin
    case (step)
      5'd0:    ra = tmask(cx[23:16]);
      5'd1:    ra = tmask(cx[23:16] + 8'd1);
      5'd2:    ra = tmask(px0 + y0);
      5'd3:    ra = tmask(px0 + y0 + 8'd1);
      5'd4:    ra = tmask(px1 + y0);
      default: ra = tmask(px1 + y0 + 8'd1);
    endcase
  end

  // shared multiplier operands
  always_comb begin
    opa = '0;
    opb = '0;
    if (state == ST_SCALE) begin
      opa = 33'($signed((step == 5'd0) ? req.px : req.py));
      opb = {6'b0, cfg.base_freq};
    end else if (state == ST_LAYER) begin
      case (step)
        5'd0:  begin opa = {17'b0, tx};  opb = {6'b0, tx}; end
        5'd1:  begin opa = {17'b0, ty};  opb = {6'b0, ty}; end
        5'd2:  begin opa = {17'b0, t2x}; opb = {6'b0, tx}; end
        5'd3:  begin opa = {17'b0, t2y}; opb = {6'b0, ty}; end
        5'd4:  begin opa = {17'b0, t3x}; opb = {6'b0, tx}; end
        5'd5:  begin opa = {17'b0, t3y}; opb = {6'b0, ty}; end
        5'd6:  begin opa = {17'b0, t4x}; opb = {6'b0, tx}; end
        5'd7:  begin opa = {17'b0, t4y}; opb = {6'b0, ty}; end
        5'd9:  begin opa = {16'b0, u};   opb = 22'(k0); end
        5'd10: begin opa = {16'b0, v};   opb = 22'(k1); end
        5'd11: begin opa = {16'b0, u};   opb = {5'b0, v}; end
        5'd12: begin opa = {15'b0, du};  opb = 22'(k0); end
        5'd13: begin opa = {15'b0, du};  opb = {5'b0, v}; end
        5'd14: begin opa = 33'(uv);      opb = 22'(k2); end
        5'd15: begin opa = 33'(duv);     opb = 22'(k2); end
        5'd16: begin opa = {15'b0, dv};  opb = 22'(k1); end
        5'd17: begin opa = {16'b0, u};   opb = {4'b0, dv}; end
        5'd18: begin opa = 33'($signed(cx)); opb = {6'b0, cfg.freq_factor}; end
        5'd19: begin opa = 33'(udv);     opb = 22'(k2); end
        5'd20: begin opa = 33'($signed(cy)); opb = {6'b0, cfg.freq_factor}; end
        5'd21: begin opa = 33'(lv);      opb = {5'b0, amp}; end
        5'd22: begin opa = {16'b0, amp}; opb = {6'b0, cfg.amp_factor}; end
        default: begin opa = '0; opb = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p <= opa * opb;
  end

  // permutation table; entries not yet written read as their own index
  always_ff @(posedge clk) begin
    if (mem_we) mem[req.idx] <= req.val;
    rq_raw <= mem[ra];
    ra_q   <= ra;
    vld_q  <= vld[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 256; i++) vld[i] <= 1'b0;
    end else if (mem_we) begin
      vld[req.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      lyr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCALE) step <= (step == SCALE_LAST) ? 5'd0 : step + 5'd1;
      else if (state == ST_LAYER) step <= (step == LAST_STEP) ? 5'd0 : step + 5'd1;
      else step <= '0;
      if (state == ST_IDLE) lyr <= '0;
      else if (state == ST_LAYER && step == LAST_STEP) lyr <= lyr + 1'b1;
    end
  end

  // datapath write-back, one product per step
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req    <= q_req;
      acc_v  <= '0;
      acc_dx <= '0;
      acc_dy <= '0;
      amp    <= FIX_ONE;
    end
    if (state == ST_SCALE) begin
      if (step == 5'd1) cx <= p[39:8];
      if (step == 5'd2) cy <= p[39:8];
    end
    if (state == ST_LAYER) begin
      case (step)
        5'd1:  begin px0 <= rq; t2x <= p[31:16]; end
        5'd2:  begin px1 <= rq; t2y <= p[31:16]; end
        5'd3:  begin ha <= rq[1:0]; t3x <= p[31:16]; end
        5'd4:  begin hc <= rq[1:0]; t3y <= p[31:16]; end
        5'd5:  begin hb <= rq[1:0]; t4x <= p[31:16]; end
        5'd6:  begin hd <= rq[1:0]; t4y <= p[31:16]; end
        5'd7:  t5x <= p[31:16];
        5'd8:  begin
          t5y <= p[31:16];
          u   <= fx.f;
          du  <= fx.df;
          a   <= ga;
          k0  <= K_W'(gb) - K_W'(ga);
          k1  <= K_W'(gc) - K_W'(ga);
          k2  <= K_W'(ga) + K_W'(gd) - K_W'(gb) - K_W'(gc);
        end
        5'd9:  begin v <= fy.f; dv <= fy.df; end
        5'd10: uk0   <= P_W'(psh);
        5'd11: vk1   <= P_W'(psh);
        5'd12: uv    <= P_W'(psh);
        5'd13: duk0  <= P_W'(psh);
        5'd14: duv   <= P_W'(psh);
        5'd15: uvk2  <= P_W'(psh);
        5'd16: duvk2 <= P_W'(psh);
        5'd17: begin
          dvk1   <= P_W'(psh);
          acc_dx <= acc_dx + ACC_W'(duk0) + ACC_W'(duvk2);
        end
        5'd18: udv <= P_W'(psh);
        5'd19: cx  <= p[39:8];
        5'd20: begin
          udvk2 <= P_W'(psh);
          lv    <= P_W'(a) + uk0 + vk1 + uvk2;
        end
        5'd21: begin
          cy     <= p[39:8];
          acc_dy <= acc_dy + ACC_W'(dvk1) + ACC_W'(udvk2);
        end
        5'd22: acc_v <= acc_v + ACC_W'(psh);
        5'd23: amp   <= p[32:16];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {sat32(acc_dy), sat32(acc_dx), sat32(acc_v)};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gradient_noise_2d_fractal_unit.sv
// Two-dimensional fractal gradient noise with derivatives, in fixed point.
// Requests enter on the s_axis channel: tuser is req_type (0 load, 1 evaluate),
// tdata carries table_index, table_value, point_x and point_y. Each request
// gives exactly one result on m_axis: noise_value, deriv_x, deriv_y (zero for
// a load, which writes one permutation table entry).
// A two-entry request queue decouples the input from the evaluation engine,
// which owns one shared multiplier and the 256-entry permutation table.
// An accepted request waits in the queue; the engine then writes the table
// entry of a load, or scales the point of an evaluation and runs each layer
// with one multiply and one table read a cycle, then loads the output register;
// requests are processed one at a time. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// Reset clears the queue, restores the register defaults and makes the table
// read as the identity permutation at once. A stalled m_axis holds its result;
// the engine waits for it, the queue fills and then s_axis_tready drops.
`default_nettype none
module gradient_noise_2d_fractal_unit
  import gnf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // table_index, table_value, point_x, point_y
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // noise_value, deriv_x, deriv_y
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg;
  logic q_valid;
  logic q_pop;
  req_t q_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_freq   <= 16'd256;
      cfg.freq_factor <= 16'd512;
      cfg.amp_factor  <= 16'd32768;
      cfg.layer_count <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_FREQ:   cfg.base_freq   <= cfg_data;
        CFG_FREQ_FACTOR: cfg.freq_factor <= cfg_data;
        CFG_AMP_FACTOR:  cfg.amp_factor  <= cfg_data;
        CFG_LAYER_COUNT: cfg.layer_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  gnf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  gnf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
